// ----- rtl/core/tdl_pkg.sv -----
// shared constants for the tree distance / lca engine
// no dependencies; imported by the top level and the ram
package tdl_pkg;

  localparam int ID_W            = 11;
  localparam int DIST_W          = 10;
  localparam int DIST_MAX        = 1023;
  localparam int MAX_NODES_DEF   = 1024;
  localparam int LIFT_LEVELS_DEF = 10;

  // item function codes
  localparam logic [1:0] FN_EDGE  = 2'd0;
  localparam logic [1:0] FN_BUILD = 2'd1;
  localparam logic [1:0] FN_QUERY = 2'd2;

endpackage

// ----- rtl/core/tree_distance_lca_engine_top.sv -----
// tree distance engine top: control sequencer and the four state memories
// depends on tdl_pkg and tdl_ram
//
// Edge words append undirected edges; a build word roots the tree at node 1,
// walks it depth first to find parent and depth of every node, then fills the
// binary-lifting ancestor table; a query word returns the edge count between
// two nodes. One word is handled at a time. An edge word is stored straight
// from the idle state. A query reads both depths, lifts the deeper node level
// by level, then lifts both nodes level by level unless the first pass already
// meets the other node; bad ids go straight to the result. A build clears and
// roots, pops each reached node and scans every stored edge for it, ends the
// walk, then fills the table level by level through the single ancestor ram
// port. After reset the block clears its whole ancestor and depth rams before
// taking the first word; configuration writes are taken at any time.
module tree_distance_lca_engine_top
  import tdl_pkg::*;
#(
  parameter int MAX_NODES   = MAX_NODES_DEF,
  parameter int LIFT_LEVELS = LIFT_LEVELS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_func,
  input  logic [ID_W-1:0]   in_node_a,
  input  logic [ID_W-1:0]   in_node_b,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [DIST_W-1:0] out_distance,
  output logic              out_bad_query,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [ID_W-1:0]   cfg_node_count
);

  localparam int NW   = $clog2(MAX_NODES + 1);
  localparam int DW   = $clog2(MAX_NODES);
  localparam int FW   = $clog2(MAX_NODES);
  localparam int SW   = $clog2(MAX_NODES);
  localparam int LW   = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1;
  localparam int AAW  = LW + NW;
  localparam int CLW  = AAW;
  localparam int SUMW = (DW + 2 > DIST_W + 1) ? DW + 2 : DIST_W + 1;
  localparam int EW   = 2 * ID_W;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_CLR  = 5'd1;
  localparam logic [4:0] S_ROOT = 5'd2;
  localparam logic [4:0] S_POP  = 5'd3;
  localparam logic [4:0] S_CUR  = 5'd4;
  localparam logic [4:0] S_CDEP = 5'd5;
  localparam logic [4:0] S_ERD  = 5'd6;
  localparam logic [4:0] S_ECHK = 5'd7;
  localparam logic [4:0] S_EVIS = 5'd8;
  localparam logic [4:0] S_L1   = 5'd9;
  localparam logic [4:0] S_L2   = 5'd10;
  localparam logic [4:0] S_L3   = 5'd11;
  localparam logic [4:0] S_QDA  = 5'd12;
  localparam logic [4:0] S_QDB  = 5'd13;
  localparam logic [4:0] S_QU1  = 5'd14;
  localparam logic [4:0] S_QU2  = 5'd15;
  localparam logic [4:0] S_QU3  = 5'd16;
  localparam logic [4:0] S_QEQ  = 5'd17;
  localparam logic [4:0] S_QV1  = 5'd18;
  localparam logic [4:0] S_QV2  = 5'd19;
  localparam logic [4:0] S_QV3  = 5'd20;
  localparam logic [4:0] S_QL1  = 5'd21;
  localparam logic [4:0] S_QL2  = 5'd22;
  localparam logic [4:0] S_QL3  = 5'd23;
  localparam logic [4:0] S_DONE = 5'd24;

  localparam logic [LW-1:0] LVL_TOP = LW'(LIFT_LEVELS - 1);

  logic [4:0]        state_r, state_nxt;
  logic [CLW-1:0]    clr_r, clr_nxt;
  logic              clr_all_r, clr_all_nxt;
  logic [ID_W-1:0]   node_count_r;
  logic [FW-1:0]     edge_fill_r, edge_fill_nxt;
  logic [SW:0]       sp_r, sp_nxt;
  logic [NW-1:0]     cur_r, cur_nxt;
  logic [DW-1:0]     cur_dep_r, cur_dep_nxt;
  logic [FW-1:0]     k_r, k_nxt;
  logic [NW-1:0]     oth_r, oth_nxt;
  logic [LW-1:0]     lvl_r, lvl_nxt;
  logic [NW-1:0]     idx_r, idx_nxt;
  logic [NW-1:0]     ua_r, ua_nxt, ub_r, ub_nxt, xa_r, xa_nxt;
  logic [DW-1:0]     da_r, da_nxt, db_r, db_nxt, tdb_r, tdb_nxt;
  logic [DIST_W-1:0] dist_r, dist_nxt;
  logic              bad_r, bad_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DIST_W-1:0] out_distance_r, out_distance_nxt;
  logic              out_bad_r, out_bad_nxt;

  logic [NW-1:0] n_eff;

  // memory ports
  logic           anc_we, anc_re;
  logic [AAW-1:0] anc_waddr, anc_raddr;
  logic [NW-1:0]  anc_wdata, anc_q;
  logic           dep_we, dep_re;
  logic [NW-1:0]  dep_waddr, dep_raddr;
  logic [DW-1:0]  dep_wdata, dep_q;
  logic           edg_we, edg_re;
  logic [FW-1:0]  edg_waddr, edg_raddr;
  logic [EW-1:0]  edg_wdata, edg_q;
  logic           stk_we, stk_re;
  logic [SW-1:0]  stk_waddr, stk_raddr;
  logic [NW-1:0]  stk_wdata, stk_q;

  // edge decode and query checks
  logic [ID_W-1:0] ea, eb;
  logic            e_ok, a_ok, b_ok;
  logic [NW-1:0]   ea_n, eb_n;
  logic [SUMW-1:0] dsum;

  // effective node count
  always_comb begin
    if (node_count_r == '0) begin
      n_eff = NW'(1);
    end else if (32'(node_count_r) > MAX_NODES) begin
      n_eff = NW'(MAX_NODES);
    end else begin
      n_eff = NW'(node_count_r);
    end
  end

  assign ea   = edg_q[ID_W-1:0];
  assign eb   = edg_q[EW-1:ID_W];
  assign ea_n = NW'(ea);
  assign eb_n = NW'(eb);
  assign e_ok = (ea != '0) && (32'(ea) <= 32'(n_eff)) &&
                (eb != '0) && (32'(eb) <= 32'(n_eff));
  assign a_ok = (in_node_a != '0) && (32'(in_node_a) <= 32'(n_eff));
  assign b_ok = (in_node_b != '0) && (32'(in_node_b) <= 32'(n_eff));

  assign dsum = SUMW'(da_r) + SUMW'(db_r) - (SUMW'(dep_q) << 1);

  assign in_stall      = (state_r != S_IDLE);
  assign cfg_ready     = 1'b1;
  assign out_valid     = out_valid_r;
  assign out_distance  = out_distance_r;
  assign out_bad_query = out_bad_r;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    clr_all_nxt   = clr_all_r;
    edge_fill_nxt = edge_fill_r;
    sp_nxt        = sp_r;
    cur_nxt       = cur_r;
    cur_dep_nxt   = cur_dep_r;
    k_nxt         = k_r;
    oth_nxt       = oth_r;
    lvl_nxt       = lvl_r;
    idx_nxt       = idx_r;
    ua_nxt        = ua_r;
    ub_nxt        = ub_r;
    xa_nxt        = xa_r;
    da_nxt        = da_r;
    db_nxt        = db_r;
    tdb_nxt       = tdb_r;
    dist_nxt      = dist_r;
    bad_nxt       = bad_r;
    anc_we = 1'b0; anc_waddr = '0; anc_wdata = '0; anc_re = 1'b0; anc_raddr = '0;
    dep_we = 1'b0; dep_waddr = '0; dep_wdata = '0; dep_re = 1'b0; dep_raddr = '0;
    edg_we = 1'b0; edg_waddr = '0; edg_wdata = '0; edg_re = 1'b0; edg_raddr = '0;
    stk_we = 1'b0; stk_waddr = '0; stk_wdata = '0; stk_re = 1'b0; stk_raddr = '0;

    out_valid_nxt    = out_valid_r && out_stall;
    out_distance_nxt = out_distance_r;
    out_bad_nxt      = out_bad_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_func)
            FN_EDGE: begin
              if (NW'(edge_fill_r) < n_eff - NW'(1)) begin
                edg_we        = 1'b1;
                edg_waddr     = edge_fill_r;
                edg_wdata     = {in_node_b, in_node_a};
                edge_fill_nxt = edge_fill_r + FW'(1);
              end
            end
            FN_BUILD: begin
              clr_nxt     = '0;
              clr_all_nxt = 1'b0;
              state_nxt   = S_CLR;
            end
            FN_QUERY: begin
              if (!a_ok || !b_ok) begin
                dist_nxt  = '0;
                bad_nxt   = 1'b1;
                state_nxt = S_DONE;
              end else begin
                ua_nxt    = NW'(in_node_a);
                ub_nxt    = NW'(in_node_b);
                dep_re    = 1'b1;
                dep_raddr = NW'(in_node_a);
                state_nxt = S_QDA;
              end
            end
            default: begin
            end
          endcase
        end
      end
      // clear sweep: whole rams after reset, level 0 and depths on build
      S_CLR: begin
        anc_we    = 1'b1;
        anc_waddr = clr_all_r ? clr_r[AAW-1:0] : {LW'(0), clr_r[NW-1:0]};
        dep_we    = 1'b1;
        dep_waddr = clr_r[NW-1:0];
        clr_nxt   = clr_r + CLW'(1);
        if (clr_all_r) begin
          if (clr_r[AAW-1:0] == {AAW{1'b1}}) begin
            state_nxt = S_IDLE;
          end
        end else if (clr_r[NW-1:0] == n_eff) begin
          state_nxt = S_ROOT;
        end
      end
      S_ROOT: begin
        anc_we    = 1'b1;
        anc_waddr = {LW'(0), NW'(1)};
        anc_wdata = NW'(1);
        stk_we    = 1'b1;
        stk_waddr = '0;
        stk_wdata = NW'(1);
        sp_nxt    = (SW+1)'(1);
        state_nxt = S_POP;
      end
      S_POP: begin
        if (sp_r == '0) begin
          lvl_nxt   = LW'(1);
          idx_nxt   = NW'(1);
          state_nxt = (LIFT_LEVELS > 1) ? S_L1 : S_IDLE;
        end else begin
          stk_re    = 1'b1;
          stk_raddr = SW'(sp_r - (SW+1)'(1));
          sp_nxt    = sp_r - (SW+1)'(1);
          state_nxt = S_CUR;
        end
      end
      S_CUR: begin
        cur_nxt   = stk_q;
        dep_re    = 1'b1;
        dep_raddr = stk_q;
        state_nxt = S_CDEP;
      end
      S_CDEP: begin
        cur_dep_nxt = dep_q;
        k_nxt       = '0;
        state_nxt   = S_ERD;
      end
      // scan stored edges for neighbors of the popped node
      S_ERD: begin
        if (k_r == edge_fill_r) begin
          state_nxt = S_POP;
        end else begin
          edg_re    = 1'b1;
          edg_raddr = k_r;
          state_nxt = S_ECHK;
        end
      end
      S_ECHK: begin
        if (e_ok && (ea_n == cur_r || eb_n == cur_r)) begin
          oth_nxt   = (ea_n == cur_r) ? eb_n : ea_n;
          anc_re    = 1'b1;
          anc_raddr = {LW'(0), ((ea_n == cur_r) ? eb_n : ea_n)};
          state_nxt = S_EVIS;
        end else begin
          k_nxt     = k_r + FW'(1);
          state_nxt = S_ERD;
        end
      end
      S_EVIS: begin
        if (oth_r != NW'(1) && anc_q == '0) begin
          anc_we    = 1'b1;
          anc_waddr = {LW'(0), oth_r};
          anc_wdata = cur_r;
          dep_we    = 1'b1;
          dep_waddr = oth_r;
          dep_wdata = cur_dep_r + DW'(1);
          if (32'(sp_r) < MAX_NODES) begin
            stk_we    = 1'b1;
            stk_waddr = SW'(sp_r);
            stk_wdata = oth_r;
            sp_nxt    = sp_r + (SW+1)'(1);
          end
        end
        k_nxt     = k_r + FW'(1);
        state_nxt = S_ERD;
      end
      // lifting table fill: anc[i][j] = anc[anc[i][j-1]][j-1]
      S_L1: begin
        anc_re    = 1'b1;
        anc_raddr = {lvl_r - LW'(1), idx_r};
        state_nxt = S_L2;
      end
      S_L2: begin
        anc_re    = 1'b1;
        anc_raddr = {lvl_r - LW'(1), anc_q};
        state_nxt = S_L3;
      end
      S_L3: begin
        anc_we    = 1'b1;
        anc_waddr = {lvl_r, idx_r};
        anc_wdata = anc_q;
        state_nxt = S_L1;
        if (idx_r == n_eff) begin
          idx_nxt = NW'(1);
          lvl_nxt = lvl_r + LW'(1);
          if (lvl_r == LVL_TOP) begin
            state_nxt = S_IDLE;
          end
        end else begin
          idx_nxt = idx_r + NW'(1);
        end
      end
      // query: depths, then order so ua is the deeper node
      S_QDA: begin
        da_nxt    = dep_q;
        dep_re    = 1'b1;
        dep_raddr = ub_r;
        state_nxt = S_QDB;
      end
      S_QDB: begin
        db_nxt  = dep_q;
        lvl_nxt = LVL_TOP;
        if (da_r < dep_q) begin
          ua_nxt  = ub_r;
          ub_nxt  = ua_r;
          tdb_nxt = da_r;
        end else begin
          tdb_nxt = dep_q;
        end
        state_nxt = S_QU1;
      end
      // lift the deeper node up to the other depth
      S_QU1: begin
        anc_re    = 1'b1;
        anc_raddr = {lvl_r, ua_r};
        state_nxt = S_QU2;
      end
      S_QU2: begin
        xa_nxt    = anc_q;
        dep_re    = 1'b1;
        dep_raddr = anc_q;
        state_nxt = S_QU3;
      end
      S_QU3: begin
        if (dep_q >= tdb_r) begin
          ua_nxt = xa_r;
        end
        if (lvl_r == '0) begin
          state_nxt = S_QEQ;
        end else begin
          lvl_nxt   = lvl_r - LW'(1);
          state_nxt = S_QU1;
        end
      end
      S_QEQ: begin
        if (ua_r == ub_r) begin
          dep_re    = 1'b1;
          dep_raddr = ua_r;
          state_nxt = S_QL3;
        end else begin
          lvl_nxt   = LVL_TOP;
          state_nxt = S_QV1;
        end
      end
      // lift both while their ancestors differ
      S_QV1: begin
        anc_re    = 1'b1;
        anc_raddr = {lvl_r, ua_r};
        state_nxt = S_QV2;
      end
      S_QV2: begin
        xa_nxt    = anc_q;
        anc_re    = 1'b1;
        anc_raddr = {lvl_r, ub_r};
        state_nxt = S_QV3;
      end
      S_QV3: begin
        if (xa_r != anc_q) begin
          ua_nxt = xa_r;
          ub_nxt = anc_q;
        end
        if (lvl_r == '0) begin
          state_nxt = S_QL1;
        end else begin
          lvl_nxt   = lvl_r - LW'(1);
          state_nxt = S_QV1;
        end
      end
      S_QL1: begin
        anc_re    = 1'b1;
        anc_raddr = {LW'(0), ua_r};
        state_nxt = S_QL2;
      end
      S_QL2: begin
        dep_re    = 1'b1;
        dep_raddr = anc_q;
        state_nxt = S_QL3;
      end
      // distance from the lca depth, clamped
      S_QL3: begin
        bad_nxt = 1'b0;
        if (dsum[SUMW-1]) begin
          dist_nxt = '0;
        end else if (dsum > SUMW'(DIST_MAX)) begin
          dist_nxt = DIST_W'(DIST_MAX);
        end else begin
          dist_nxt = DIST_W'(dsum);
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt    = 1'b1;
          out_distance_nxt = dist_r;
          out_bad_nxt      = bad_r;
          state_nxt        = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      clr_r        <= '0;
      clr_all_r    <= 1'b1;
      node_count_r <= ID_W'(1);
      edge_fill_r  <= '0;
      sp_r         <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      clr_all_r   <= clr_all_nxt;
      edge_fill_r <= edge_fill_nxt;
      sp_r        <= sp_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        node_count_r <= cfg_node_count;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r          <= cur_nxt;
    cur_dep_r      <= cur_dep_nxt;
    k_r            <= k_nxt;
    oth_r          <= oth_nxt;
    lvl_r          <= lvl_nxt;
    idx_r          <= idx_nxt;
    ua_r           <= ua_nxt;
    ub_r           <= ub_nxt;
    xa_r           <= xa_nxt;
    da_r           <= da_nxt;
    db_r           <= db_nxt;
    tdb_r          <= tdb_nxt;
    dist_r         <= dist_nxt;
    bad_r          <= bad_nxt;
    out_distance_r <= out_distance_nxt;
    out_bad_r      <= out_bad_nxt;
  end

  // ancestor table, level in the upper address bits
  tdl_ram #(.W(NW), .AW(AAW)) u_anc (
    .clk(clk), .we(anc_we), .waddr(anc_waddr), .wdata(anc_wdata),
    .re(anc_re), .raddr(anc_raddr), .rdata(anc_q)
  );

  // node depths
  tdl_ram #(.W(DW), .AW(NW)) u_dep (
    .clk(clk), .we(dep_we), .waddr(dep_waddr), .wdata(dep_wdata),
    .re(dep_re), .raddr(dep_raddr), .rdata(dep_q)
  );

  // edge store
  tdl_ram #(.W(EW), .AW(FW)) u_edg (
    .clk(clk), .we(edg_we), .waddr(edg_waddr), .wdata(edg_wdata),
    .re(edg_re), .raddr(edg_raddr), .rdata(edg_q)
  );

  // walk stack
  tdl_ram #(.W(NW), .AW(SW)) u_stk (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .re(stk_re), .raddr(stk_raddr), .rdata(stk_q)
  );

`ifndef ASSERT_OFF
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_bad_r |-> out_distance_r == '0)
    else $error("bad query word with nonzero distance");

  a_sp_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(sp_r) <= MAX_NODES)
    else $error("walk stack overflow");

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(edge_fill_r) < MAX_NODES)
    else $error("edge fill beyond store");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    $past(out_valid_r && out_stall) |-> out_valid_r && $stable(out_distance_r))
    else $error("pending result word lost");
`endif

endmodule

// ----- rtl/core/tdl_ram.sv -----
// single port write, single port read synchronous ram, registered read data
// depends on tdl_pkg
module tdl_ram
  import tdl_pkg::*;
#(
  parameter int W  = ID_W,
  parameter int AW = ID_W
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [2**AW];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, read data registered when re is high
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- tb/tb_tree_distance_lca_engine_top.sv -----
// self-checking testbench for the tree distance / lca engine top level
// depends on tdl_pkg and the engine rtl; carries its own tree model for prediction
`timescale 1ns / 100ps

module tb_tree_distance_lca_engine_top;
  import tdl_pkg::*;

  localparam int NODES  = MAX_NODES_DEF;
  localparam int LEVELS = LIFT_LEVELS_DEF;

  typedef struct {
    logic [DIST_W-1:0] distance;
    logic              bad_query;
  } path_result_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [1:0]        in_func;
  logic [ID_W-1:0]   in_node_a;
  logic [ID_W-1:0]   in_node_b;
  logic              out_valid;
  logic              out_stall;
  logic [DIST_W-1:0] out_distance;
  logic              out_bad_query;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [ID_W-1:0]   cfg_node_count;

  tree_distance_lca_engine_top dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_func       (in_func),
    .in_node_a     (in_node_a),
    .in_node_b     (in_node_b),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_distance  (out_distance),
    .out_bad_query (out_bad_query),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_node_count(cfg_node_count)
  );

  // tree model state
  logic [ID_W-1:0] node_count_reg;
  logic [ID_W-1:0] edge_a [0:NODES-2];
  logic [ID_W-1:0] edge_b [0:NODES-2];
  int              edges_held;
  logic [ID_W-1:0] parent_tbl [0:NODES][0:LEVELS-1];
  int              depth_tbl [0:NODES];

  path_result_t expected_paths[$];
  int           fail_count;
  int           burst_left;
  int           hold_ticket;
  int           nodes_grown;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  initial begin
    #200_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic int active_nodes();
    if (node_count_reg < 1) return 1;
    if (node_count_reg > NODES) return NODES;
    return int'(node_count_reg);
  endfunction

  function automatic bit id_in_range(int v, int n);
    return v >= 1 && v <= n;
  endfunction

  // root at node 1, depth first walk over stored edges, then lifting fill
  function automatic void rebuild_tree();
    int n;
    int cur;
    int other;
    int ea;
    int eb;
    int pending[$];
    n = active_nodes();
    for (int i = 0; i <= NODES; i++) begin
      depth_tbl[i] = 0;
      for (int j = 0; j < LEVELS; j++) parent_tbl[i][j] = '0;
    end
    parent_tbl[1][0] = ID_W'(1);
    pending = {pending, 1};
    while (pending.size() > 0) begin
      cur = pending.pop_back();
      for (int k = 0; k < edges_held; k++) begin
        ea = int'(edge_a[k]);
        eb = int'(edge_b[k]);
        if (!id_in_range(ea, n) || !id_in_range(eb, n)) continue;
        if (ea == cur) other = eb;
        else if (eb == cur) other = ea;
        else continue;
        if (other == 1 || parent_tbl[other][0] != 0) continue;
        parent_tbl[other][0] = ID_W'(cur);
        depth_tbl[other] = depth_tbl[cur] + 1;
        if (pending.size() < NODES) pending = {pending, other};
      end
    end
    for (int j = 1; j < LEVELS; j++)
      for (int i = 1; i <= n; i++)
        parent_tbl[i][j] = parent_tbl[parent_tbl[i][j-1]][j-1];
  endfunction

  function automatic int lowest_common(int a, int b);
    int t;
    if (depth_tbl[a] < depth_tbl[b]) begin
      t = a;
      a = b;
      b = t;
    end
    for (int i = LEVELS - 1; i >= 0; i--)
      if (depth_tbl[parent_tbl[a][i]] >= depth_tbl[b]) a = int'(parent_tbl[a][i]);
    if (a == b) return a;
    for (int i = LEVELS - 1; i >= 0; i--)
      if (parent_tbl[a][i] != parent_tbl[b][i]) begin
        a = int'(parent_tbl[a][i]);
        b = int'(parent_tbl[b][i]);
      end
    return int'(parent_tbl[a][0]);
  endfunction

  // apply one accepted word to the model
  function automatic void apply_word(logic [1:0] func, int a, int b);
    int n;
    int d;
    path_result_t r;
    n = active_nodes();
    case (func)
      FN_EDGE: begin
        if (edges_held < n - 1 && edges_held < NODES - 1) begin
          edge_a[edges_held] = ID_W'(a);
          edge_b[edges_held] = ID_W'(b);
          edges_held++;
        end
      end
      FN_BUILD: rebuild_tree();
      FN_QUERY: begin
        if (!id_in_range(a, n) || !id_in_range(b, n)) begin
          r.distance  = '0;
          r.bad_query = 1'b1;
        end else begin
          d = depth_tbl[a] + depth_tbl[b] - 2 * depth_tbl[lowest_common(a, b)];
          if (d < 0) d = 0;
          if (d > DIST_MAX) d = DIST_MAX;
          r.distance  = DIST_W'(d);
          r.bad_query = 1'b0;
        end
        expected_paths = {expected_paths, r};
      end
      default: ;
    endcase
  endfunction

  // send one word, bursts with random gaps in between
  task automatic send_word(logic [1:0] func, int a, int b);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid  <= 1'b1;
    in_func   <= func;
    in_node_a <= ID_W'(a);
    in_node_b <= ID_W'(b);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    apply_word(func, a, b);
  endtask

  // query fence: the engine takes one word at a time, so its result means idle
  task automatic settle();
    send_word(FN_QUERY, 1, 1);
    in_valid <= 1'b0;
    while (expected_paths.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_node_count(int value);
    cfg_valid      <= 1'b1;
    cfg_node_count <= ID_W'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    node_count_reg = ID_W'(value);
    @(posedge clk);
  endtask

  function automatic int pick_query_id(int n);
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 2047);
      1: return 0;
      default: return $urandom_range(1, n);
    endcase
  endfunction

  // grow the tree: each new node hangs under a random earlier node
  task automatic grow_nodes(int upto);
    int ids[$];
    int j;
    int t;
    for (int v = nodes_grown + 1; v <= upto; v++) ids = {ids, v};
    for (int i = ids.size() - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = ids[i];
      ids[i] = ids[j];
      ids[j] = t;
    end
    foreach (ids[i]) begin
      if ($urandom_range(0, 1)) send_word(FN_EDGE, ids[i], $urandom_range(1, ids[i] - 1));
      else send_word(FN_EDGE, $urandom_range(1, ids[i] - 1), ids[i]);
    end
    if (upto > nodes_grown) nodes_grown = upto;
  endtask

  task automatic test_directed();
    // reset count of one, queries before any build
    send_word(FN_QUERY, 1, 1);
    send_word(FN_QUERY, 0, 1);
    send_word(FN_QUERY, 2, 1);
    settle();
    write_node_count(6);
    send_word(FN_EDGE, 1, 2);
    send_word(FN_EDGE, 3, 2);
    send_word(FN_EDGE, 3, 3);      // self loop
    send_word(FN_EDGE, 0, 5);      // bad endpoint, stored but skipped
    send_word(FN_EDGE, 4, 1);
    send_word(FN_EDGE, 4, 6);      // beyond edge limit, ignored
    send_word(FN_QUERY, 3, 4);     // tables still clear
    send_word(FN_BUILD, 0, 0);
    send_word(FN_QUERY, 3, 4);
    send_word(FN_QUERY, 5, 3);     // unreachable node
    send_word(FN_QUERY, 2, 2);
    send_word(FN_QUERY, 6, 1024);
    send_word(FN_QUERY, 2047, 1);
    send_word(2'd3, 2047, 2047);   // unknown func
    send_word(FN_BUILD, 2047, 2047); // rebuild
    send_word(FN_QUERY, 4, 3);
    settle();
    write_node_count(0);           // acts as one
    send_word(FN_QUERY, 1, 1);
    send_word(FN_QUERY, 1, 2);
    send_word(FN_BUILD, 0, 0);
    settle();
    nodes_grown = 6;
  endtask

  task automatic test_random_trees();
    int n;
    int phase_words;
    for (int phase = 0; phase < 14; phase++) begin
      n = nodes_grown + $urandom_range(6, 18);
      write_node_count(n);
      grow_nodes(n);
      if ($urandom_range(0, 4) == 0)
        send_word(FN_EDGE, $urandom_range(0, 2047), $urandom_range(0, 2047));
      // sometimes shrink the count so stored edges go out of range
      if ($urandom_range(0, 3) == 0) begin
        settle();
        write_node_count($urandom_range(2, n));
        n = active_nodes();
      end
      send_word(FN_BUILD, $urandom_range(0, 2047), $urandom_range(0, 2047));
      phase_words = $urandom_range(80, 120);
      for (int i = 0; i < phase_words; i++) begin
        case ($urandom_range(0, 39))
          0: send_word(FN_BUILD, 0, 0);
          1: send_word(2'd3, $urandom_range(0, 2047), $urandom_range(0, 2047));
          2: send_word(FN_EDGE, $urandom_range(0, 2047), $urandom_range(0, 2047));
          default: send_word(FN_QUERY, pick_query_id(n), pick_query_id(n));
        endcase
      end
      settle();
    end
  endtask

  task automatic test_backpressure();
    hold_ticket++;
    for (int i = 0; i < 30; i++)
      send_word(FN_QUERY, pick_query_id(active_nodes()), pick_query_id(active_nodes()));
    settle();
  endtask

  task automatic test_full_size();
    int v;
    write_node_count(2047);        // acts as the maximum
    send_word(FN_EDGE, 1, 1024);
    send_word(FN_EDGE, 1024, 1023);
    for (int i = 0; i < 12; i++) begin
      v = $urandom_range(nodes_grown + 1, 1022);
      send_word(FN_EDGE, v, $urandom_range(1, nodes_grown));
    end
    send_word(FN_BUILD, 0, 0);
    for (int i = 0; i < 60; i++) begin
      if ($urandom_range(0, 2) == 0) send_word(FN_QUERY, 1023, $urandom_range(0, 2047));
      else send_word(FN_QUERY, pick_query_id(1024), pick_query_id(1024));
    end
    settle();
    write_node_count(1024);
    send_word(FN_BUILD, 0, 0);
    for (int i = 0; i < 40; i++)
      send_word(FN_QUERY, pick_query_id(1024), $urandom_range(1, nodes_grown));
    settle();
    write_node_count(1);
    send_word(FN_BUILD, 0, 0);
    send_word(FN_QUERY, 1, 1);
    send_word(FN_QUERY, 1, 2);
    settle();
  endtask

  // receiver: long hold on request, otherwise a changing stall pattern
  int hold_seen;
  int hold_left;
  int stall_mode;
  int mode_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_seen <= 0;
      hold_left <= 0;
      stall_mode <= 0;
      mode_left <= 0;
    end else if (hold_seen != hold_ticket) begin
      hold_seen <= hold_ticket;
      hold_left <= 400;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= (hold_left > 1);
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        mode_left <= $urandom_range(20, 300);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= 1'($urandom_range(0, 1));
        default: out_stall <= (mode_left % 7) < 3;
      endcase
    end
  end

  // result check against the oldest expectation
  always @(posedge clk) begin
    path_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_paths.size() == 0) begin
        $error("unexpected result word: distance %0d bad_query %0b",
               out_distance, out_bad_query);
        fail_count++;
      end else begin
        want = expected_paths.pop_front();
        if (out_distance !== want.distance) begin
          $error("distance: expected %0d, got %0d", want.distance, out_distance);
          fail_count++;
        end
        if (out_bad_query !== want.bad_query) begin
          $error("bad_query: expected %0b, got %0b", want.bad_query, out_bad_query);
          fail_count++;
        end
      end
    end
  end

  // main sequence
  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_func        = FN_EDGE;
    in_node_a      = '0;
    in_node_b      = '0;
    cfg_valid      = 1'b0;
    cfg_node_count = '0;
    fail_count     = 0;
    burst_left     = 0;
    hold_ticket    = 0;
    nodes_grown    = 0;
    node_count_reg = ID_W'(1);
    edges_held     = 0;
    for (int i = 0; i <= NODES; i++) begin
      depth_tbl[i] = 0;
      for (int j = 0; j < LEVELS; j++) parent_tbl[i][j] = '0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_trees();
    test_backpressure();
    test_full_size();

    in_valid <= 1'b0;
    while (expected_paths.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0 && expected_paths.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/tdl_pkg.sv
rtl/core/tdl_ram.sv
rtl/core/tree_distance_lca_engine_top.sv
tb/tb_tree_distance_lca_engine_top.sv
